### rtl/trickle_timer_bank_unit_assert.svh
// Assertion macros for the trickle timer bank.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef TRICKLE_TIMER_BANK_UNIT_ASSERT_SVH
`define TRICKLE_TIMER_BANK_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define TTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ttb_pkg.sv
// Shared types, constants and helpers for the trickle timer bank.
// No dependencies.
`timescale 1ns / 1ps

package ttb_pkg;

    localparam int TIMERS     = 4;
    localparam int MAX_EVENTS = 4;
    localparam int WORD_W     = 32;
    localparam int SEED_W     = 16;
    localparam int TIDX_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int EVT_CNT_W  = $clog2(MAX_EVENTS + 1);
    localparam int STEP_W     = $clog2(WORD_W + 1);

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        timer_id;
        logic [WORD_W-1:0] min_interval;
        logic [WORD_W-1:0] max_interval;
    } ttb_cmd_t;

    typedef struct packed {
        logic [1:0]        fired_timer;
        logic [WORD_W-1:0] new_interval;
        logic [WORD_W-1:0] next_fire_time;
        logic              last;
    } ttb_evt_t;

    typedef struct packed {
        logic              go;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } ttb_mod_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } ttb_mod_rsp_t;

    // xorshift32 step; the new state is the draw
    function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        begin
            y = x ^ (x << 13);
            y = y ^ (y >> 17);
            y = y ^ (y << 5);
            return y;
        end
    endfunction

endpackage

### rtl/ttb_mod_unit.sv
// Shared iterative remainder unit: restoring division, one bit per cycle.
// Depends on ttb_pkg. A zero divisor gives a zero remainder.
`timescale 1ns / 1ps

module ttb_mod_unit
    import ttb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ttb_mod_req_t req,
    output ttb_mod_rsp_t rsp
);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        if (req.go)
        begin
            active_next = 1'b1;
            cnt_next    = STEP_W'(WORD_W);
            rem_next    = '0;
            dvd_next    = req.dividend;
            dvs_next    = req.divisor;
        end
        else if (active_reg)
        begin
            rem_next = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = (dvs_reg == '0) ? '0 : rem_reg;

endmodule

### rtl/trickle_timer_bank_unit.sv
// Top level of the trickle timer bank: sequencer, timer state and event output.
// Depends on ttb_pkg, ttb_mod_unit and trickle_timer_bank_unit_assert.svh.
`timescale 1ns / 1ps
`include "trickle_timer_bank_unit_assert.svh"

//  channel   signals                        beat taken when
//  --------  -----------------------------  -------------------------------
//  command   start, busy, cmd               start && !busy
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//  event     evt_strobe, evt                every cycle evt_strobe is high
//
// Stop and unused modes keep the sequencer idle. A start makes two passes through
// the shared remainder unit (32 steps each) between its control states. A tick
// scans every timer, then takes each fired timer through select, advance, draw
// and remainder, walking past each index below the last fired timer, with up to
// MAX_EVENTS fired timers per tick.
// Reset (rst_n, async, active low) clears time, running bits, seed and the
// generator state (to one); per-timer registers hold junk until a start.
// The event side cannot stall: each event beat lasts exactly one cycle.
// cfg_ready is always high; writes are expected only while busy is low.

module trickle_timer_bank_unit
    import ttb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ttb_cmd_t          cmd,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SEED_W-1:0] cfg_data,
    output logic              evt_strobe,
    output ttb_evt_t          evt
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;  // build the due mask, one timer a cycle
    localparam logic [2:0] ST_NEXT  = 3'd2;  // walk to the next due timer
    localparam logic [2:0] ST_ADV   = 3'd3;  // move start on, double interval up to the cap
    localparam logic [2:0] ST_DRAW  = 3'd4;  // draw and launch fire-time remainder
    localparam logic [2:0] ST_WAIT  = 3'd5;  // write fire time, emit on tick
    localparam logic [2:0] ST_SDRAW = 3'd6;  // start: draw and launch offset remainder
    localparam logic [2:0] ST_SWAIT = 3'd7;  // start: write start, interval, cap

    // control
    logic [2:0]           state_reg, state_next;
    logic [TIDX_W-1:0]    idx_reg, idx_next;
    logic [TIMERS-1:0]    mask_reg, mask_next;
    logic [EVT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 tick_reg, tick_next;
    logic [WORD_W-1:0]    time_reg, time_next;
    logic [WORD_W-1:0]    rng_reg, rng_next;
    logic [SEED_W-1:0]    seed_reg;
    logic [TIMERS-1:0]    running_reg;
    logic                 strobe_reg, strobe_next;

    // payload
    logic [WORD_W-1:0]    base_reg, base_next;
    logic [WORD_W-1:0]    imin_reg, imin_next;
    logic [WORD_W-1:0]    imax_reg, imax_next;
    ttb_evt_t             evt_reg, evt_next;

    // per-timer state, undefined until a start writes it
    logic [WORD_W-1:0]    start_arr_reg [TIMERS];
    logic [WORD_W-1:0]    fire_arr_reg  [TIMERS];
    logic [WORD_W-1:0]    iv_arr_reg    [TIMERS];
    logic [WORD_W-1:0]    cap_arr_reg   [TIMERS];

    ttb_mod_req_t         mod_req;
    ttb_mod_rsp_t         mod_rsp;

    logic                 accept;
    logic                 id_ok;
    logic [TIDX_W-1:0]    cmd_idx;
    logic [WORD_W-1:0]    cur_iv;
    logic [WORD_W-1:0]    half;
    logic [WORD_W-1:0]    draw_val;
    logic [WORD_W-1:0]    fire_lag;
    logic                 due;
    logic [WORD_W-1:0]    dbl;
    logic [WORD_W-1:0]    dbl_capped;
    logic [WORD_W-1:0]    fire_val;
    logic [TIMERS-1:0]    idx_bit;

    assign accept   = start && !busy;
    assign cmd_idx  = TIDX_W'(cmd.timer_id);
    assign id_ok    = 32'(cmd.timer_id) < 32'(TIMERS);
    assign cur_iv   = iv_arr_reg[idx_reg];
    assign half     = cur_iv >> 1;
    assign draw_val = xorshift32(rng_reg);

    // due when fire time is not after now (wrapping signed compare)
    assign fire_lag = fire_arr_reg[idx_reg] - time_reg;
    assign due      = running_reg[idx_reg] && ((fire_lag == '0) || fire_lag[WORD_W-1]);

    // double with saturation, then cap
    assign dbl        = cur_iv[WORD_W-1] ? '1 : (cur_iv << 1);
    assign dbl_capped = (dbl > cap_arr_reg[idx_reg]) ? cap_arr_reg[idx_reg] : dbl;

    assign fire_val = base_reg + mod_rsp.remainder;
    assign idx_bit  = TIMERS'(1) << idx_reg;

    // the shared remainder unit serves both start offset and fire draw
    assign mod_req.go       = (state_reg == ST_DRAW) || (state_reg == ST_SDRAW);
    assign mod_req.dividend = draw_val;
    assign mod_req.divisor  = (state_reg == ST_SDRAW) ? imin_reg : (cur_iv - half);

    ttb_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        cnt_next    = cnt_reg;
        tick_next   = tick_reg;
        time_next   = time_reg;
        rng_next    = rng_reg;
        strobe_next = 1'b0;
        base_next   = base_reg;
        imin_next   = imin_reg;
        imax_next   = imax_reg;
        evt_next    = evt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == MODE_TICK)
                    begin
                        time_next  = time_reg + WORD_W'(1);
                        idx_next   = '0;
                        mask_next  = '0;
                        cnt_next   = '0;
                        tick_next  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if ((cmd.mode == MODE_START) && id_ok)
                    begin
                        rng_next   = (seed_reg == '0) ? WORD_W'(1) : WORD_W'(seed_reg);
                        idx_next   = cmd_idx;
                        imin_next  = cmd.min_interval;
                        imax_next  = cmd.max_interval;
                        tick_next  = 1'b0;
                        state_next = ST_SDRAW;
                    end
                end
            end
            ST_SCAN:
            begin
                mask_next[idx_reg] = due;
                if (idx_reg == TIDX_W'(TIMERS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_NEXT;
                end
                else
                begin
                    idx_next = idx_reg + TIDX_W'(1);
                end
            end
            ST_NEXT:
            begin
                if ((mask_reg == '0) || (cnt_reg == EVT_CNT_W'(MAX_EVENTS)))
                    state_next = ST_IDLE;
                else if (mask_reg[idx_reg])
                    state_next = ST_ADV;
                else
                    idx_next = idx_reg + TIDX_W'(1);
            end
            ST_ADV:
            begin
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                rng_next   = draw_val;
                base_next  = start_arr_reg[idx_reg] + half;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    if (tick_reg)
                    begin
                        evt_next.fired_timer    = 2'(idx_reg);
                        evt_next.new_interval   = cur_iv;
                        evt_next.next_fire_time = fire_val;
                        evt_next.last           = ((mask_reg & ~idx_bit) == '0) ||
                                                  (cnt_reg == EVT_CNT_W'(MAX_EVENTS - 1));
                        strobe_next = 1'b1;
                        mask_next   = mask_reg & ~idx_bit;
                        cnt_next    = cnt_reg + EVT_CNT_W'(1);
                        state_next  = ST_NEXT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SDRAW:
            begin
                rng_next   = draw_val;
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                if (mod_rsp.done)
                    state_next = ST_DRAW;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            mask_reg   <= '0;
            cnt_reg    <= '0;
            tick_reg   <= 1'b0;
            time_reg   <= '0;
            rng_reg    <= WORD_W'(1);
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            mask_reg   <= mask_next;
            cnt_reg    <= cnt_next;
            tick_reg   <= tick_next;
            time_reg   <= time_next;
            rng_reg    <= rng_next;
            strobe_reg <= strobe_next;
        end
    end

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_valid && cfg_ready)
            seed_reg <= cfg_data;
    end

    // running bits: set on start, cleared on stop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
        end
        else if (accept && id_ok)
        begin
            if (cmd.mode == MODE_START)
                running_reg[cmd_idx] <= 1'b1;
            else if (cmd.mode == MODE_STOP)
                running_reg[cmd_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        imin_reg <= imin_next;
        imax_reg <= imax_next;
        evt_reg  <= evt_next;
        if (state_reg == ST_ADV)
        begin
            start_arr_reg[idx_reg] <= start_arr_reg[idx_reg] + cur_iv;
            iv_arr_reg[idx_reg]    <= dbl_capped;
        end
        if ((state_reg == ST_SWAIT) && mod_rsp.done)
        begin
            start_arr_reg[idx_reg] <= time_reg + mod_rsp.remainder;
            iv_arr_reg[idx_reg]    <= imin_reg;
            cap_arr_reg[idx_reg]   <= imax_reg;
        end
        if ((state_reg == ST_WAIT) && mod_rsp.done)
            fire_arr_reg[idx_reg] <= fire_val;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign evt_strobe = strobe_reg;
    assign evt        = evt_reg;

    // events only come out of a tick in progress
    `TTB_ASSERT_NOW(a_evt_while_busy, evt_strobe, busy && tick_reg, "event outside a tick")
    // remainder unit only finishes while the sequencer waits on it
    `TTB_ASSERT_NOW(a_mod_done_in_wait, mod_rsp.done,
        (state_reg == ST_WAIT) || (state_reg == ST_SWAIT), "stray remainder done")
    // a tick advances the time counter by exactly one
    `TTB_ASSERT_NEXT(a_tick_adv, accept && (cmd.mode == MODE_TICK),
        time_reg == $past(time_reg) + WORD_W'(1), "tick did not advance time")

endmodule
